// ===== rtl/lgs_pkg.sv =====
// Shared types and constants for the life grid generation step unit.
package lgs_pkg;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int OP_W      = 2;
    localparam int COORD_W   = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRID_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] CFG_GRID_RESET = 7'd64;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // B3/S23 neighbor counts
    localparam logic [3:0] LIFE_BIRTH = 4'd3;
    localparam logic [3:0] LIFE_KEEP  = 4'd2;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               cell_value;
    } t_op_item;

    typedef struct packed {
        logic            read_state;
        logic [OP_W-1:0] done_operation;
    } t_result;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ACC_RD,
        S_FETCH0,
        S_SHIFT0,
        S_FETCH,
        S_SHIFT,
        S_CELL,
        S_WRITE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic step_init;
        logic fetch;
        logic shift;
        logic cell_eval;
        logic wr_row;
        logic acc_rd;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic            clr_last;
        logic            row_last;
        logic            col_last;
        logic            empty;
        logic [OP_W-1:0] op;
    } t_dp_stat;

endpackage

// ===== rtl/lgs_ctrl.sv =====
// Sequencer for clear pass, cell access and generation step.
module lgs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  lgs_pkg::t_dp_stat i_stat,
    output lgs_pkg::t_dp_cmd  o_cmd
);
    import lgs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.op) inside
                    OP_WRITE, OP_READ: n_state = S_ACC_RD;
                    OP_STEP: n_state = i_stat.empty ? S_FINISH : S_FETCH0;
                    default: n_state = S_FINISH;
                endcase
            end
            S_ACC_RD: n_state = S_FINISH;
            S_FETCH0: n_state = S_SHIFT0;
            S_SHIFT0: n_state = S_FETCH;
            S_FETCH:  n_state = S_SHIFT;
            S_SHIFT:  n_state = S_CELL;
            S_CELL: begin
                if (i_stat.col_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = i_stat.row_last ? S_FINISH : S_FETCH;
            end
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        busy            = 1'b1;
        unique case (r_state)
            S_CLEAR:  o_cmd.clr_wr = 1'b1;
            S_IDLE: begin
                busy         = 1'b0;
                o_cmd.accept = start;
            end
            S_DECODE: o_cmd.step_init = (i_stat.op == OP_STEP);
            S_ACC_RD: o_cmd.acc_rd = 1'b1;
            S_FETCH0: o_cmd.fetch = 1'b1;
            S_SHIFT0: o_cmd.shift = 1'b1;
            S_FETCH:  o_cmd.fetch = 1'b1;
            S_SHIFT:  o_cmd.shift = 1'b1;
            S_CELL:   o_cmd.cell_eval = 1'b1;
            S_WRITE:  o_cmd.wr_row = 1'b1;
            S_FINISH: o_cmd.finish = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/lgs_datapath.sv =====
// Grid row memory, three-row window, cell rule and result register.
module lgs_datapath #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lgs_pkg::t_op_item             i_cmd,
    input  logic                          i_cfg_we,
    input  logic [lgs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]     i_cfg_data,
    input  lgs_pkg::t_dp_cmd              i_ctl,
    output lgs_pkg::t_dp_stat             o_stat,
    output logic                          o_result_valid,
    output lgs_pkg::t_result              o_result
);
    import lgs_pkg::*;

    localparam int CI_W = $clog2(MAX_COLS);
    localparam int RA_W = $clog2(MAX_ROWS);
    localparam int WC_W = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;
    localparam int WR_W = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;

    // grid storage, one row per word
    logic [MAX_COLS-1:0] r_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] r_rdata;
    logic                mem_we;
    logic [RA_W-1:0]     mem_waddr;
    logic [MAX_COLS-1:0] mem_wdata;
    logic                mem_re;
    logic [RA_W-1:0]     mem_raddr;

    logic [CFG_W-1:0]    r_grid_width;
    logic [CFG_W-1:0]    r_grid_height;
    t_op_item            r_in;

    logic [MAX_COLS-1:0] r_prev;
    logic [MAX_COLS-1:0] r_cur;
    logic [MAX_COLS-1:0] r_next;
    logic [MAX_COLS-1:0] r_new;
    logic [CI_W-1:0]     r_col;
    logic [RA_W-1:0]     r_row;
    logic [WR_W-1:0]     r_fetch;
    logic                r_fetch_ok;
    t_result             r_result;
    logic                r_result_valid;

    logic [WC_W-1:0]     w_act;
    logic [WR_W-1:0]     h_act;
    logic [WC_W-1:0]     cfg_w_ext;
    logic [WR_W-1:0]     cfg_h_ext;
    logic [WC_W-1:0]     in_col_ext;
    logic [WR_W-1:0]     in_row_ext;
    logic [CI_W-1:0]     in_col_idx;
    logic [RA_W-1:0]     in_row_idx;
    logic                in_area;
    logic                fetch_ok;

    logic [CI_W-1:0]     idx_l;
    logic [CI_W-1:0]     idx_r;
    logic                has_l;
    logic                has_r;
    logic [7:0]          nbr;
    logic [3:0]          nbr_cnt;
    logic                new_bit;
    logic [MAX_COLS-1:0] patched_row;

    function automatic logic [3:0] count8(input logic [7:0] bits);
        logic [3:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            acc = acc + {3'b000, bits[i]};
        end
        return acc;
    endfunction

    // active area, saturated to the array size
    assign cfg_w_ext  = WC_W'(r_grid_width);
    assign cfg_h_ext  = WR_W'(r_grid_height);
    assign w_act      = (cfg_w_ext > WC_W'(MAX_COLS)) ? WC_W'(MAX_COLS) : cfg_w_ext;
    assign h_act      = (cfg_h_ext > WR_W'(MAX_ROWS)) ? WR_W'(MAX_ROWS) : cfg_h_ext;

    assign in_col_ext = WC_W'(r_in.col);
    assign in_row_ext = WR_W'(r_in.row);
    assign in_col_idx = in_col_ext[CI_W-1:0];
    assign in_row_idx = in_row_ext[RA_W-1:0];
    assign in_area    = (in_col_ext < w_act) && (in_row_ext < h_act);
    assign fetch_ok   = (r_fetch < h_act);

    assign o_stat.clr_last = (r_row == RA_W'(MAX_ROWS - 1));
    assign o_stat.row_last = ((WR_W'(r_row) + WR_W'(1)) == h_act);
    assign o_stat.col_last = ((WC_W'(r_col) + WC_W'(1)) == w_act);
    assign o_stat.empty    = (w_act == '0) || (h_act == '0);
    assign o_stat.op       = r_in.operation;

    // neighborhood of the current column
    assign has_l   = (r_col != '0);
    assign has_r   = ((WC_W'(r_col) + WC_W'(1)) < w_act);
    assign idx_l   = has_l ? (r_col - CI_W'(1)) : r_col;
    assign idx_r   = (r_col == CI_W'(MAX_COLS - 1)) ? r_col : (r_col + CI_W'(1));
    assign nbr     = {r_prev[idx_l] & has_l, r_prev[r_col], r_prev[idx_r] & has_r,
                      r_cur[idx_l] & has_l,                 r_cur[idx_r] & has_r,
                      r_next[idx_l] & has_l, r_next[r_col], r_next[idx_r] & has_r};
    assign nbr_cnt = count8(nbr);
    assign new_bit = (nbr_cnt == LIFE_BIRTH) || (r_cur[r_col] && (nbr_cnt == LIFE_KEEP));

    always_comb begin
        patched_row             = r_rdata;
        patched_row[in_col_idx] = r_in.cell_value;
    end

    // memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_row;
        mem_wdata = '0;
        if (i_ctl.clr_wr) begin
            mem_we = 1'b1;
        end else if (i_ctl.wr_row) begin
            mem_we    = 1'b1;
            mem_wdata = r_new;
        end else if (i_ctl.finish && (r_in.operation == OP_WRITE) && in_area) begin
            mem_we    = 1'b1;
            mem_waddr = in_row_idx;
            mem_wdata = patched_row;
        end
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = in_row_idx;
        if (i_ctl.fetch) begin
            mem_re    = fetch_ok;
            mem_raddr = r_fetch[RA_W-1:0];
        end else if (i_ctl.acc_rd) begin
            mem_re = in_area;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= CFG_GRID_RESET;
            r_grid_height <= CFG_GRID_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_IDX_GRID_WIDTH) begin
                r_grid_width <= i_cfg_data;
            end
            if (i_cfg_index == CFG_IDX_GRID_HEIGHT) begin
                r_grid_height <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row          <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= i_ctl.finish;
            if (i_ctl.step_init) begin
                r_row <= '0;
            end else if (i_ctl.clr_wr || i_ctl.wr_row) begin
                r_row <= r_row + RA_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_in <= i_cmd;
        end
        if (i_ctl.step_init) begin
            r_prev  <= '0;
            r_cur   <= '0;
            r_next  <= '0;
            r_fetch <= '0;
        end
        if (i_ctl.fetch) begin
            r_fetch_ok <= fetch_ok;
            r_fetch    <= r_fetch + WR_W'(1);
        end
        if (i_ctl.shift) begin
            r_prev <= r_cur;
            r_cur  <= r_next;
            r_next <= r_fetch_ok ? r_rdata : '0;
            r_new  <= r_next;
            r_col  <= '0;
        end
        if (i_ctl.cell_eval) begin
            r_new[r_col] <= new_bit;
            r_col        <= r_col + CI_W'(1);
        end
        if (i_ctl.finish) begin
            r_result.read_state     <= (r_in.operation == OP_READ) && in_area
                                       && r_rdata[in_col_idx];
            r_result.done_operation <= r_in.operation;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

// ===== rtl/life_grid_generation_step_unit.sv =====
// Top level of the life grid generation step unit (B3/S23, dead border).
//
// Usage: a command transaction is taken when start is high and busy is low;
// its payload i_cmd carries operation, col, row and cell_value. Exactly one
// result per command appears on o_result for a single cycle, flagged by
// o_result_valid; the receiver has no way to stall it, so it must sample.
// Config: grid_width (index 0) and grid_height (index 1) are written over
// i_cfg_valid/o_cfg_ready (ready is always high); write them only while idle.
// Sequence: a write or read passes decode, a memory read and finish before
// the result strobe; the unused code and a step over an empty area go from
// decode to finish. A step walks the active area one cell per cycle within
// a row, with a three-row window fed by the row memory, fetching, shifting
// and writing back a row between rows; the grid memory's one read port and
// the cell loop set how long it runs. One command is in flight at a time.
// Reset: the grid memory is swept to all-dead, one row per cycle, and
// busy stays high during the sweep. Sizes reset to 64 by 64.
module life_grid_generation_step_unit #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  lgs_pkg::t_op_item             i_cmd,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lgs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_result_valid,
    output lgs_pkg::t_result              o_result
);
    import lgs_pkg::*;

    t_dp_cmd  ctl_cmd;
    t_dp_stat ctl_stat;

    // register writes never stall
    assign o_cfg_ready = 1'b1;

    lgs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (ctl_stat),
        .o_cmd   (ctl_cmd)
    );

    lgs_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (i_cmd),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_ctl          (ctl_cmd),
        .o_stat         (ctl_stat),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule
